>>> sv/matrix_compose_and_point_transform_unit_macros.svh
// ----------------------------------------------------------------------------
// matrix_compose_and_point_transform_unit_macros.svh
// Assertion macros shared by the matrix unit modules. They expect signals
// named clk and rst in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef MATRIX_COMPOSE_AND_POINT_TRANSFORM_UNIT_MACROS_SVH
`define MATRIX_COMPOSE_AND_POINT_TRANSFORM_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MCPT_CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MCPT_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mcpt_pkg.sv
// ----------------------------------------------------------------------------
// mcpt_pkg
// Types and fixed widths shared by the matrix compose / point transform unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcpt_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_WR_CUR  = 2'd0,
    REQ_WR_OPD  = 2'd1,
    REQ_COMPOSE = 2'd2,
    REQ_XFORM   = 2'd3
  } req_kind_t;

  // Read addresses into both matrices
  typedef struct packed {
    logic [IDX_W-1:0] cur_addr;
    logic [IDX_W-1:0] opd_addr;
  } mat_rd_t;

  // Write command into the matrix store
  typedef struct packed {
    logic              cur_en;
    logic              opd_en;
    logic              shadow;  // write the inactive current bank
    logic              swap;    // make the inactive bank the current one
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } mat_wr_t;

  // Tag riding along with one multiply term
  typedef struct packed {
    logic             first;
    logic             last;
    logic [IDX_W-1:0] elem;
  } mac_tag_t;

  // Saturated dot-product result
  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         elem;
    logic signed [DATA_W-1:0] value;
    logic                     hit;
  } mac_res_t;

endpackage

>>> sv/mcpt_req_if.sv
// ----------------------------------------------------------------------------
// mcpt_req_if
// Request channel: element writes, compose and point transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcpt_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [mcpt_pkg::IDX_W-1:0]       elem_index;
  logic signed [mcpt_pkg::DATA_W-1:0] elem_value;
  logic signed [mcpt_pkg::DATA_W-1:0] point_x;
  logic signed [mcpt_pkg::DATA_W-1:0] point_y;
  logic signed [mcpt_pkg::DATA_W-1:0] point_z;

  modport source (
    output valid, req_type, elem_index, elem_value, point_x, point_y, point_z,
    input  ready
  );

  modport sink (
    input  valid, req_type, elem_index, elem_value, point_x, point_y, point_z,
    output ready
  );
endinterface

>>> sv/mcpt_res_if.sv
// ----------------------------------------------------------------------------
// mcpt_res_if
// Result channel: transformed point and saturation flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mcpt_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [mcpt_pkg::DATA_W-1:0] out_x;
  logic signed [mcpt_pkg::DATA_W-1:0] out_y;
  logic signed [mcpt_pkg::DATA_W-1:0] out_z;
  logic                               clipped;

  modport source (
    output valid, out_x, out_y, out_z, clipped,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, clipped,
    output ready
  );
endinterface

>>> sv/mcpt_mat_store.sv
// ----------------------------------------------------------------------------
// mcpt_mat_store
// Current matrix (two banks, ping-pong on compose) and operand matrix.
// One write and one registered read per matrix per cycle. Entries never
// written since reset read as identity (current) or zero (operand).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcpt_mat_store #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mcpt_pkg::mat_rd_t                  rd,
  input  mcpt_pkg::mat_wr_t                  wr,
  output logic signed [mcpt_pkg::DATA_W-1:0] cur_data,
  output logic signed [mcpt_pkg::DATA_W-1:0] opd_data
);
  import mcpt_pkg::*;

  localparam int DEPTH = 16;
  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) <<< FRAC_BITS;

  logic signed [DATA_W-1:0] cur_mem [2*DEPTH];
  logic signed [DATA_W-1:0] opd_mem [DEPTH];
  logic                     bank;
  logic [DEPTH-1:0]         cur_vld;
  logic [DEPTH-1:0]         opd_vld;
  logic signed [DATA_W-1:0] cur_q;
  logic signed [DATA_W-1:0] opd_q;
  logic                     cur_vq;
  logic                     opd_vq;
  logic                     cur_diag;

  // Track bank select and written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      bank    <= 1'b0;
      cur_vld <= '0;
      opd_vld <= '0;
    end else begin
      if (wr.cur_en && !wr.shadow) begin
        cur_vld[wr.idx] <= 1'b1;
      end
      if (wr.opd_en) begin
        opd_vld[wr.idx] <= 1'b1;
      end
      if (wr.swap) begin
        bank    <= ~bank;
        cur_vld <= '1;
      end
    end
  end

  // Write and read both arrays
  always_ff @(posedge clk) begin
    if (wr.cur_en) begin
      cur_mem[{wr.shadow ^ bank, wr.idx}] <= wr.data;
    end
    if (wr.opd_en) begin
      opd_mem[wr.idx] <= wr.data;
    end
    cur_q    <= cur_mem[{bank, rd.cur_addr}];
    opd_q    <= opd_mem[rd.opd_addr];
    cur_vq   <= cur_vld[rd.cur_addr];
    opd_vq   <= opd_vld[rd.opd_addr];
    cur_diag <= (rd.cur_addr[1:0] == rd.cur_addr[3:2]);
  end

  // Substitute reset contents for unwritten entries
  always_comb begin
    if (cur_vq) begin
      cur_data = cur_q;
    end else if (cur_diag) begin
      cur_data = ONE_Q;
    end else begin
      cur_data = '0;
    end
    opd_data = opd_vq ? opd_q : '0;
  end

endmodule

>>> sv/mcpt_mac.sv
// ----------------------------------------------------------------------------
// mcpt_mac
// Shared multiply / round / accumulate / saturate pipeline. One term enters
// per cycle; a group of terms tagged first..last gives one saturated sum once
// its last term passes the product, round, accumulate and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix_compose_and_point_transform_unit_macros.svh"

module mcpt_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_vld,
  input  mcpt_pkg::mac_tag_t                 in_tag,
  input  logic signed [mcpt_pkg::DATA_W-1:0] a,
  input  logic signed [mcpt_pkg::DATA_W-1:0] b,
  output mcpt_pkg::mac_res_t                 res
);
  import mcpt_pkg::*;

  localparam int ACC_W = 2 * DATA_W;
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) <<< (DATA_W - 1));

  logic                     p_vld;
  mac_tag_t                 p_tag;
  logic signed [ACC_W-1:0]  prod;
  logic                     r_vld;
  mac_tag_t                 r_tag;
  logic signed [ACC_W-1:0]  rnd;
  logic                     c_vld;
  logic [IDX_W-1:0]         c_elem;
  logic signed [ACC_W-1:0]  acc;
  logic                     o_vld;
  logic [IDX_W-1:0]         o_elem;
  logic signed [DATA_W-1:0] o_value;
  logic                     o_hit;

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      r_vld <= 1'b0;
      c_vld <= 1'b0;
      o_vld <= 1'b0;
    end else begin
      p_vld <= in_vld;
      r_vld <= p_vld;
      c_vld <= r_vld && r_tag.last;
      o_vld <= c_vld;
    end
  end

  // Multiply, round, accumulate, saturate
  always_ff @(posedge clk) begin
    prod  <= ACC_W'(a) * ACC_W'(b);
    p_tag <= in_tag;
    rnd   <= (prod + HALF) >>> FRAC_BITS;
    r_tag <= p_tag;
    if (r_vld) begin
      acc    <= r_tag.first ? rnd : acc + rnd;
      c_elem <= r_tag.elem;
    end
    o_elem <= c_elem;
    if (acc > SAT_MAX) begin
      o_value <= SAT_MAX[DATA_W-1:0];
      o_hit   <= 1'b1;
    end else if (acc < SAT_MIN) begin
      o_value <= SAT_MIN[DATA_W-1:0];
      o_hit   <= 1'b1;
    end else begin
      o_value <= acc[DATA_W-1:0];
      o_hit   <= 1'b0;
    end
  end

  assign res.valid = o_vld;
  assign res.elem  = o_elem;
  assign res.value = o_value;
  assign res.hit   = o_hit;

  `MCPT_CHK_IMP(a_res_after_last, o_vld, $past(in_vld && in_tag.last, 4), "mac result without a closing term")
  `MCPT_CHK_IMP(a_terms_contiguous, in_vld && !in_tag.first, $past(in_vld), "gap inside a dot product")
  `MCPT_CHK_IMP(a_hit_at_limit, o_vld && o_hit, o_value == SAT_MAX[DATA_W-1:0] || o_value == SAT_MIN[DATA_W-1:0], "saturation flag without clamped value")

endmodule

>>> sv/mcpt_seq.sv
// ----------------------------------------------------------------------------
// mcpt_seq
// Request sequencer: takes element writes at once, walks the compose and
// transform terms through the shared multiply pipeline, writes compose
// results back and holds the transform result for the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix_compose_and_point_transform_unit_macros.svh"

module mcpt_seq #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  mcpt_req_if.sink                           req,
  mcpt_res_if.source                         res,
  output mcpt_pkg::mat_rd_t                  rd,
  output mcpt_pkg::mat_wr_t                  wr,
  input  logic signed [mcpt_pkg::DATA_W-1:0] cur_data,
  input  logic signed [mcpt_pkg::DATA_W-1:0] opd_data,
  output logic                               mac_vld,
  output mcpt_pkg::mac_tag_t                 mac_tag,
  output logic signed [mcpt_pkg::DATA_W-1:0] mac_a,
  output logic signed [mcpt_pkg::DATA_W-1:0] mac_b,
  input  mcpt_pkg::mac_res_t                 mac_res
);
  import mcpt_pkg::*;

  localparam logic [1:0]       TERM_X = 2'd0;
  localparam logic [1:0]       TERM_Y = 2'd1;
  localparam logic [1:0]       TERM_Z = 2'd2;
  localparam logic [1:0]       TERM_LAST = 2'd3;
  localparam logic [IDX_W-1:0] XFORM_LAST_ELEM   = IDX_W'(2);
  localparam logic [IDX_W-1:0] COMPOSE_LAST_ELEM = IDX_W'(15);
  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) <<< FRAC_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PUB
  } state_t;

  state_t                   state;
  req_kind_t                kind;
  logic                     accept;
  logic                     xform;
  logic [1:0]               term;
  logic [IDX_W-1:0]         elem;
  logic [IDX_W-1:0]         last_elem;
  logic                     res_done;
  logic signed [DATA_W-1:0] px;
  logic signed [DATA_W-1:0] py;
  logic signed [DATA_W-1:0] pz;
  logic                     s1_vld;
  mac_tag_t                 s1_tag;
  logic [1:0]               s1_term;
  logic signed [DATA_W-1:0] wx;
  logic signed [DATA_W-1:0] wy;
  logic signed [DATA_W-1:0] wz;
  logic                     whit;
  logic                     res_vld;
  logic signed [DATA_W-1:0] ox;
  logic signed [DATA_W-1:0] oy;
  logic signed [DATA_W-1:0] oz;
  logic                     oclip;

  assign kind      = req_kind_t'(req.req_type);
  assign req.ready = (state == ST_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign last_elem = xform ? XFORM_LAST_ELEM : COMPOSE_LAST_ELEM;
  assign res_done  = mac_res.valid && (mac_res.elem == last_elem);

  // Term k of element e: current[k*4+row], operand[col*4+k]
  assign rd.cur_addr = {term, elem[1:0]};
  assign rd.opd_addr = {elem[3:2], term};

  // Route element writes and compose write-back to the store
  always_comb begin
    wr = '0;
    if (accept && kind == REQ_WR_CUR) begin
      wr.cur_en = 1'b1;
      wr.idx    = req.elem_index;
      wr.data   = req.elem_value;
    end else if (accept && kind == REQ_WR_OPD) begin
      wr.opd_en = 1'b1;
      wr.idx    = req.elem_index;
      wr.data   = req.elem_value;
    end else if (!xform && mac_res.valid) begin
      wr.cur_en = 1'b1;
      wr.shadow = 1'b1;
      wr.swap   = res_done;
      wr.idx    = mac_res.elem;
      wr.data   = mac_res.value;
    end
  end

  // Pick the second factor: operand element or point coordinate
  always_comb begin
    if (!xform) begin
      mac_b = opd_data;
    end else begin
      case (s1_term)
        TERM_X:  mac_b = px;
        TERM_Y:  mac_b = py;
        TERM_Z:  mac_b = pz;
        default: mac_b = ONE_Q;
      endcase
    end
  end

  assign mac_a   = cur_data;
  assign mac_vld = s1_vld;
  assign mac_tag = s1_tag;

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      xform   <= 1'b0;
      term    <= '0;
      elem    <= '0;
      s1_vld  <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      s1_vld <= (state == ST_RUN);
      // Load a finished transform, else drop a result once taken
      if (state == ST_PUB && (!res_vld || res.ready)) begin
        res_vld <= 1'b1;
      end else if (res_vld && res.ready) begin
        res_vld <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (kind == REQ_COMPOSE || kind == REQ_XFORM)) begin
            xform <= (kind == REQ_XFORM);
            term  <= '0;
            elem  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          term <= term + 2'd1;
          if (term == TERM_LAST) begin
            elem <= elem + IDX_W'(1);
            if (elem == last_elem) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (res_done) begin
            state <= xform ? ST_PUB : ST_IDLE;
          end
        end
        ST_PUB: begin
          if (!res_vld || res.ready) begin
            ox      <= wx;
            oy      <= wy;
            oz      <= wz;
            oclip   <= whit;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Latch the point, tag issued terms, collect transform components
  always_ff @(posedge clk) begin
    if (accept) begin
      px   <= req.point_x;
      py   <= req.point_y;
      pz   <= req.point_z;
      whit <= 1'b0;
    end else if (xform && mac_res.valid) begin
      whit <= whit | mac_res.hit;
    end
    s1_tag.first <= (term == TERM_X);
    s1_tag.last  <= (term == TERM_LAST);
    s1_tag.elem  <= elem;
    s1_term      <= term;
    if (xform && mac_res.valid) begin
      case (mac_res.elem[1:0])
        2'd0:    wx <= mac_res.value;
        2'd1:    wy <= mac_res.value;
        default: wz <= mac_res.value;
      endcase
    end
  end

  assign res.valid   = res_vld;
  assign res.out_x   = ox;
  assign res.out_y   = oy;
  assign res.out_z   = oz;
  assign res.clipped = oclip;

  `MCPT_CHK_IMP(a_res_only_busy, mac_res.valid, state == ST_RUN || state == ST_DRAIN, "pipeline result while not working")
  `MCPT_CHK_NXT(a_pub_loads, state == ST_PUB && (!res_vld || res.ready), res_vld && state == ST_IDLE, "transform result not published")
  `MCPT_CHK_IMP(a_shadow_compose, wr.shadow, !xform && !req.ready, "bank write outside compose")

endmodule

>>> sv/matrix_compose_and_point_transform_unit.sv
// ----------------------------------------------------------------------------
// matrix_compose_and_point_transform_unit
// 4x4 column-major fixed-point matrix unit: element writes, compose
// (current = current * operand) and affine point transform with saturation.
// ----------------------------------------------------------------------------
//  Channel | Side | Carries
//  --------+------+--------------------------------------------------------
//  req     | in   | req_type, elem_index, elem_value, point_x/y/z
//  res     | out  | out_x, out_y, out_z, clipped (transform only)
//
//  Element writes may follow back to back.
//  Transform: 12 terms through the single shared multiplier, one per cycle,
//  then the pipeline drains; ready returns once the result is published.
//  Compose: 64 terms through the same multiplier, written back before ready.
//  Reset is synchronous; the matrices read as identity and zero at once.
//  A finished transform loads the output register at once if it is empty;
//  otherwise it waits for res.ready and ready stays low meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_compose_and_point_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mcpt_req_if.sink   req,
  mcpt_res_if.source res
);
  import mcpt_pkg::*;

  mat_rd_t                  rd;
  mat_wr_t                  wr;
  logic signed [DATA_W-1:0] cur_data;
  logic signed [DATA_W-1:0] opd_data;
  logic                     mac_vld;
  mac_tag_t                 mac_tag;
  logic signed [DATA_W-1:0] mac_a;
  logic signed [DATA_W-1:0] mac_b;
  mac_res_t                 mac_res;

  mcpt_mat_store #(
    .FRAC_BITS (FRAC_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd       (rd),
    .wr       (wr),
    .cur_data (cur_data),
    .opd_data (opd_data)
  );

  mcpt_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .in_vld (mac_vld),
    .in_tag (mac_tag),
    .a      (mac_a),
    .b      (mac_b),
    .res    (mac_res)
  );

  mcpt_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res      (res),
    .rd       (rd),
    .wr       (wr),
    .cur_data (cur_data),
    .opd_data (opd_data),
    .mac_vld  (mac_vld),
    .mac_tag  (mac_tag),
    .mac_a    (mac_a),
    .mac_b    (mac_b),
    .mac_res  (mac_res)
  );

endmodule
